### rtl/lifn_pkg.sv
// ----------------------------------------------------------------------------
// lifn_pkg: shared types and constants for the LIF neuron update block
// Sizes, register indexes, word types and fixed-point helpers.
// ----------------------------------------------------------------------------
package lifn_pkg;

    localparam int NEURONS        = 1024;
    localparam int SLOTS          = 16;
    localparam int TABLE_CAPACITY = 1024;
    localparam int REFRAC_STEPS   = 20;
    localparam int BASE_ID        = 0;

    localparam int NEURON_W = 10;
    localparam int NEURON_AW = $clog2(NEURONS);
    localparam int SLOT_W   = 4;
    localparam int SLOT_AW  = $clog2(SLOTS);
    localparam int FILL_W   = 11;
    localparam int POS_W    = 10;

    localparam logic [NEURON_W:0]  NEURON_LIMIT = (NEURON_W + 1)'(NEURONS);
    localparam logic [FILL_W-1:0]  FILL_CAP     = FILL_W'(TABLE_CAPACITY);
    localparam logic [7:0]         REFRAC_LOAD  = 8'(REFRAC_STEPS);
    localparam logic [POS_W-1:0]   BASE_ID_W    = POS_W'(BASE_ID);

    // register indexes on the config port
    localparam logic [2:0] REG_REST      = 3'd0;
    localparam logic [2:0] REG_MEM_DECAY = 3'd1;
    localparam logic [2:0] REG_EXC_GAIN  = 3'd2;
    localparam logic [2:0] REG_INH_GAIN  = 3'd3;
    localparam logic [2:0] REG_EXC_DECAY = 3'd4;
    localparam logic [2:0] REG_INH_DECAY = 3'd5;
    localparam logic [2:0] REG_THRESHOLD = 3'd6;
    localparam logic [2:0] REG_RESET_POT = 3'd7;

    localparam logic signed [31:0] REST_INIT = -32'sd4587520;

    typedef struct packed {
        logic signed [31:0] rest;
        logic [16:0]        mem_decay;
        logic signed [31:0] exc_gain;
        logic signed [31:0] inh_gain;
        logic [16:0]        exc_decay;
        logic [16:0]        inh_decay;
        logic signed [31:0] threshold;
        logic signed [31:0] reset_pot;
    } t_cfg;

    // classified item passed from front to back
    typedef struct packed {
        logic [NEURON_W-1:0] neuron;
        logic signed [31:0]  excite_in;
        logic signed [31:0]  inhibit_in;
        logic signed [31:0]  drive;
        logic signed [31:0]  slow;
        logic [SLOT_AW-1:0]  slot;
        logic                new_step;
        logic                in_range;
    } t_item;

    // per-neuron state, one memory word
    typedef struct packed {
        logic signed [31:0] membrane;
        logic [7:0]         refr;
        logic signed [31:0] exc_cur;
        logic signed [31:0] inh_cur;
        logic [31:0]        tally;
    } t_state;

    localparam int STATE_W = $bits(t_state);

    localparam t_state STATE_INIT = '{membrane: REST_INIT, refr: 8'd0, exc_cur: 32'sd0,
                                      inh_cur: 32'sd0, tally: 32'd0};

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] r;
        if (v > 50'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -50'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### rtl/lifn_in_if.sv
// ----------------------------------------------------------------------------
// lifn_in_if: input word channel
// Valid/ready channel carrying one neuron step request.
// ----------------------------------------------------------------------------
interface lifn_in_if;
    logic               valid;
    logic               ready;
    logic [9:0]         neuron;
    logic signed [31:0] excite_in;
    logic signed [31:0] inhibit_in;
    logic signed [31:0] external_drive;
    logic signed [31:0] slow_current;
    logic [3:0]         time_slot;
    logic               new_step;

    modport source (output valid, neuron, excite_in, inhibit_in, external_drive,
                    slow_current, time_slot, new_step, input ready);
    modport sink (input valid, neuron, excite_in, inhibit_in, external_drive,
                  slow_current, time_slot, new_step, output ready);
endinterface

### rtl/lifn_out_if.sv
// ----------------------------------------------------------------------------
// lifn_out_if: result word channel
// Valid/ready channel carrying one neuron step result.
// ----------------------------------------------------------------------------
interface lifn_out_if;
    logic               valid;
    logic               ready;
    logic [9:0]         neuron_id;
    logic               fired;
    logic [3:0]         table_slot;
    logic [9:0]         table_position;
    logic               table_full;
    logic signed [31:0] membrane;
    logic [31:0]        spike_count;

    modport source (output valid, neuron_id, fired, table_slot, table_position,
                    table_full, membrane, spike_count, input ready);
    modport sink (input valid, neuron_id, fired, table_slot, table_position,
                  table_full, membrane, spike_count, output ready);
endinterface

### rtl/lifn_ram.sv
// ----------------------------------------------------------------------------
// lifn_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lifn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/lifn_front.sv
// ----------------------------------------------------------------------------
// lifn_front: input side
// Accepts words, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module lifn_front
    import lifn_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    lifn_in_if.sink i_in,
    input  logic  i_pop,
    output logic  o_head_valid,
    output t_item o_head
);
    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_item      item;
    logic       push;

    always_comb begin
        item.neuron     = i_in.neuron;
        item.excite_in  = i_in.excite_in;
        item.inhibit_in = i_in.inhibit_in;
        item.drive      = i_in.external_drive;
        item.slow       = i_in.slow_current;
        item.slot       = i_in.time_slot[SLOT_AW-1:0];   // modulo SLOTS
        item.new_step   = i_in.new_step;
        item.in_range   = ({1'b0, i_in.neuron} < NEURON_LIMIT);
    end

    assign i_in.ready   = (r_cnt != 2'd2);
    assign push         = i_in.valid && i_in.ready;
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end
endmodule

### rtl/lifn_back.sv
// ----------------------------------------------------------------------------
// lifn_back: update pipeline
// State read, products, sum/fire/write-back, result register.
// ----------------------------------------------------------------------------
module lifn_back
    import lifn_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_head_valid,
    input  t_item i_head,
    output logic  o_pop,
    output logic  o_clr_busy,
    lifn_out_if.source o_out
);
    // clearing pass
    logic                 r_clr_busy;
    logic [NEURON_AW-1:0] r_clr_addr;

    // stage 1: state word arriving from RAM
    logic   r1_v;
    t_item  r1_item;
    t_state rd_state;
    logic [STATE_W-1:0] rd_data;

    // stage 2: products
    logic               r2_v;
    t_item              r2_item;
    t_state             r2_st;
    logic signed [50:0] r2_pm;
    logic signed [63:0] r2_pe, r2_pi;
    logic signed [49:0] r2_pee, r2_pes, r2_pii;

    // slot fill counters
    logic [FILL_W-1:0] r_fill [SLOTS];

    // result register
    logic               r_out_valid;
    logic [9:0]         r_id;
    logic               r_fired;
    logic [3:0]         r_slot;
    logic [9:0]         r_pos;
    logic               r_full;
    logic signed [31:0] r_memb;
    logic [31:0]        r_count;

    logic adv, hazard, we;
    logic [NEURON_AW-1:0] waddr;
    logic [STATE_W-1:0]   wdata;

    logic signed [32:0] dv;
    logic signed [17:0] md18, ed18, id18, one_m_ed;

    logic signed [49:0] sum_m, sum_e, sum_i;
    logic signed [31:0] memb_new, memb_fin, cur_e, cur_i;
    logic               fire;
    logic [FILL_W-1:0]  fill_cur, fill_nxt;
    logic [POS_W-1:0]   pos;
    logic               full;
    t_state             st_new;

    assign adv      = !r_out_valid || o_out.ready;
    assign hazard   = (r1_v && r1_item.neuron == i_head.neuron)
                   || (r2_v && r2_item.neuron == i_head.neuron);
    assign o_pop    = i_head_valid && adv && !r_clr_busy && !hazard;
    assign o_clr_busy = r_clr_busy;

    assign rd_state = t_state'(rd_data);

    // stage 1 products
    assign md18     = $signed({1'b0, i_cfg.mem_decay});
    assign ed18     = $signed({1'b0, i_cfg.exc_decay});
    assign id18     = $signed({1'b0, i_cfg.inh_decay});
    assign one_m_ed = 18'sd65536 - ed18;
    assign dv       = 33'(rd_state.membrane) - 33'(i_cfg.rest);

    // stage 2 sums, threshold, slot
    always_comb begin
        sum_m = 50'(r2_pm >>> 16) + 50'(r2_pe >>> 16) + 50'(r2_pi >>> 16)
              + 50'(r2_item.drive) + 50'(i_cfg.rest);
        sum_e = (r2_pee >>> 16) + (r2_pes >>> 16) + 50'(r2_item.excite_in);
        sum_i = (r2_pii >>> 16) + 50'(r2_item.inhibit_in);
        memb_new = (r2_st.refr == 8'd0) ? sat32(sum_m) : r2_st.membrane;
        cur_e    = sat32(sum_e);
        cur_i    = sat32(sum_i);
        fire     = r2_item.in_range && (memb_new >= i_cfg.threshold);

        fill_cur = r2_item.new_step ? '0 : r_fill[r2_item.slot];
        fill_nxt = fill_cur;
        pos      = '0;
        full     = 1'b0;
        if (fire) begin
            if (fill_cur < FILL_CAP) begin
                pos      = fill_cur[POS_W-1:0];
                fill_nxt = fill_cur + FILL_W'(1);
            end else begin
                full = 1'b1;
            end
        end

        memb_fin         = fire ? i_cfg.reset_pot : memb_new;
        st_new.membrane  = memb_fin;
        st_new.exc_cur   = cur_e;
        st_new.inh_cur   = cur_i;
        st_new.tally     = (fire && r2_st.tally != 32'hFFFFFFFF) ? r2_st.tally + 32'd1
                                                                 : r2_st.tally;
        if (fire) begin
            st_new.refr = REFRAC_LOAD;
        end else if (r2_st.refr != 8'd0) begin
            st_new.refr = r2_st.refr - 8'd1;
        end else begin
            st_new.refr = 8'd0;
        end
    end

    assign we    = r_clr_busy || (adv && r2_v && r2_item.in_range);
    assign waddr = r_clr_busy ? r_clr_addr : r2_item.neuron[NEURON_AW-1:0];
    assign wdata = r_clr_busy ? STATE_INIT : st_new;

    lifn_ram #(.WIDTH(STATE_W), .DEPTH(NEURONS)) u_state (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (o_pop),
        .i_raddr (i_head.neuron[NEURON_AW-1:0]),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_item <= i_head;
            r2_item <= r1_item;
            r2_st   <= rd_state;
            r2_pm   <= dv * md18;
            r2_pe   <= rd_state.exc_cur * i_cfg.exc_gain;
            r2_pi   <= rd_state.inh_cur * i_cfg.inh_gain;
            r2_pee  <= rd_state.exc_cur * ed18;
            r2_pes  <= one_m_ed * r1_item.slow;
            r2_pii  <= rd_state.inh_cur * id18;
            if (r2_v) begin
                r_id    <= BASE_ID_W + r2_item.neuron;
                r_fired <= fire;
                r_slot  <= 4'(r2_item.slot);
                r_pos   <= pos;
                r_full  <= full;
                r_memb  <= r2_item.in_range ? memb_fin : 32'sd0;
                r_count <= r2_item.in_range ? st_new.tally : 32'd0;
            end
        end
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r1_v        <= 1'b0;
            r2_v        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int s = 0; s < SLOTS; s++) begin
                r_fill[s] <= '0;
            end
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + NEURON_AW'(1);
                if (r_clr_addr == NEURON_AW'(NEURONS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (adv) begin
                r1_v        <= o_pop;
                r2_v        <= r1_v;
                r_out_valid <= r2_v;
                if (r2_v) begin
                    r_fill[r2_item.slot] <= fill_nxt;
                end
            end
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.neuron_id      = r_id;
    assign o_out.fired          = r_fired;
    assign o_out.table_slot     = r_slot;
    assign o_out.table_position = r_pos;
    assign o_out.table_full     = r_full;
    assign o_out.membrane       = r_memb;
    assign o_out.spike_count    = r_count;
endmodule

### rtl/lif_neuron_update.sv
// ----------------------------------------------------------------------------
// lif_neuron_update: leaky integrate-and-fire neuron step engine
// Advances one neuron by one time step per input word.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one word per neuron step (index, weighted spikes, drive,
//   slow current, fire-table slot, new-step flag). o_out returns exactly one
//   result word per input word, in order: id, fired, slot, table position,
//   full flag, membrane and spike count after the step.
//   Config is a plain write port (i_cfg_we/i_cfg_idx/i_cfg_data); write only
//   while idle. Registers take their defaults at reset.
// Timing:
//   A word is queued in the cycle it is accepted, then goes through stage 1
//   (state read), stage 2 (products) and the result register to o_out. One
//   word per cycle for distinct neurons while o_out is not held; the state
//   read/write loop spans both stages: a word for a neuron in them waits.
// Reset:
//   Synchronous, active low. A clearing pass then sweeps all 1024 words of the
//   neuron state memory; the two-word input queue fills meanwhile but no word
//   is processed until the pass ends.
// Stall:
//   When o_out is held, the pipeline freezes; the input keeps taking words
//   until the queue is full.
// ----------------------------------------------------------------------------
module lif_neuron_update
    import lifn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    lifn_in_if.sink     i_in,
    lifn_out_if.source  o_out
);
    t_cfg  r_cfg;
    logic  head_valid, pop, clr_busy;
    t_item head;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rest      <= REST_INIT;
            r_cfg.mem_decay <= 17'd65000;
            r_cfg.exc_gain  <= 32'sd65;
            r_cfg.inh_gain  <= 32'sd65;
            r_cfg.exc_decay <= 17'd64000;
            r_cfg.inh_decay <= 17'd64000;
            r_cfg.threshold <= -32'sd3604480;
            r_cfg.reset_pot <= -32'sd4587520;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_REST:      r_cfg.rest      <= i_cfg_data;
                REG_MEM_DECAY: r_cfg.mem_decay <= i_cfg_data[16:0];
                REG_EXC_GAIN:  r_cfg.exc_gain  <= i_cfg_data;
                REG_INH_GAIN:  r_cfg.inh_gain  <= i_cfg_data;
                REG_EXC_DECAY: r_cfg.exc_decay <= i_cfg_data[16:0];
                REG_INH_DECAY: r_cfg.inh_decay <= i_cfg_data[16:0];
                REG_THRESHOLD: r_cfg.threshold <= i_cfg_data;
                REG_RESET_POT: r_cfg.reset_pot <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lifn_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    lifn_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_clr_busy   (clr_busy),
        .o_out        (o_out)
    );

    // nothing leaves the queue while the state memory is being cleared
    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |-> !pop) else $error("word popped during clearing pass");

    // pop only from a non-empty queue
    a_pop_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> head_valid) else $error("pop from empty queue");

    // a table position is only handed out for a spike
    a_pos_needs_spike: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.fired) |-> (o_out.table_position == 10'd0
                                           && !o_out.table_full))
        else $error("table position without spike");

    // no result right after reset
    a_quiet_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid) else $error("result after reset");
endmodule

### dv/lif_neuron_update_test.sv
// ----------------------------------------------------------------------------
// lif_neuron_update_test: self-checking bench for the LIF neuron step engine
// Random and directed step words with a bit-exact predictor of neuron state,
// random idling on both channels and register writes between phases.
// ----------------------------------------------------------------------------
module lif_neuron_update_test
    import lifn_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [9:0]         neuron;
        logic signed [31:0] excite_in;
        logic signed [31:0] inhibit_in;
        logic signed [31:0] drive;
        logic signed [31:0] slow;
        logic [3:0]         slot;
        logic               new_step;
    } t_step;

    typedef struct packed {
        logic [9:0]         neuron_id;
        logic               fired;
        logic [3:0]         slot;
        logic [9:0]         position;
        logic               full;
        logic signed [31:0] membrane;
        logic [31:0]        count;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_idx = REG_REST;
    logic [31:0] i_cfg_data = '0;

    lifn_in_if  step_ch ();
    lifn_out_if res_ch ();

    lif_neuron_update DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (step_ch.sink),
        .o_out      (res_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // predictor copy of registers and neuron state
    t_cfg               cfg;
    logic signed [31:0] mem_v   [NEURONS];
    logic [7:0]         refr_v  [NEURONS];
    logic signed [31:0] exc_v   [NEURONS];
    logic signed [31:0] inh_v   [NEURONS];
    logic [31:0]        tally_v [NEURONS];
    logic [10:0]        fill_v  [SLOTS];

    t_step   pending_steps[$];
    t_result expected_results[$];
    int      errors = 0;
    int      idle_cycles = 0;

    // products are exact; arithmetic right shift floors
    function automatic logic signed [63:0] mulq(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [63:0] p;
        p = a * b;
        return p >>> 16;
    endfunction

    function automatic logic signed [31:0] clamp(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction

    function automatic t_result advance_neuron(input t_step s);
        t_result r;
        logic signed [63:0] v, ie, ii, el, sum;
        int n;
        r = '0;
        n = s.neuron;
        r.neuron_id = 10'(BASE_ID + n);
        r.slot = s.slot;
        if (s.new_step) fill_v[s.slot] = '0;
        if (n < NEURONS) begin
            v = mem_v[n];
            ie = exc_v[n];
            ii = inh_v[n];
            el = cfg.rest;
            if (refr_v[n] == 0) begin
                sum = mulq(v - el, {47'd0, cfg.mem_decay}) + mulq(ie, cfg.exc_gain)
                    + mulq(ii, cfg.inh_gain) + s.drive + el;
                mem_v[n] = clamp(sum);
            end else begin
                refr_v[n] = refr_v[n] - 8'd1;
            end
            exc_v[n] = clamp(mulq(ie, {47'd0, cfg.exc_decay})
                + mulq(64'sd65536 - {47'd0, cfg.exc_decay}, s.slow) + s.excite_in);
            inh_v[n] = clamp(mulq(ii, {47'd0, cfg.inh_decay}) + s.inhibit_in);
            if (mem_v[n] >= cfg.threshold) begin
                r.fired = 1'b1;
                if (tally_v[n] != 32'hFFFFFFFF) tally_v[n]++;
                if (fill_v[s.slot] < TABLE_CAPACITY) begin
                    r.position = fill_v[s.slot][9:0];
                    fill_v[s.slot]++;
                end else begin
                    r.full = 1'b1;
                end
                refr_v[n] = 8'(REFRAC_STEPS);
                mem_v[n] = cfg.reset_pot;
            end
            r.membrane = mem_v[n];
            r.count = tally_v[n];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // driver: one word from the queue at a time, random gaps
    // ------------------------------------------------------------------
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (step_ch.valid && step_ch.ready) begin
            expected_results.push_back(advance_neuron(pending_steps.pop_front()));
        end
        if (!step_ch.valid || step_ch.ready) begin
            // an accepted head is already gone, so [0] is the next word
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                step_ch.valid <= 1'b0;
            end else if (pending_steps.size() > 0) begin
                step_ch.valid          <= 1'b1;
                step_ch.neuron         <= pending_steps[0].neuron;
                step_ch.excite_in      <= pending_steps[0].excite_in;
                step_ch.inhibit_in     <= pending_steps[0].inhibit_in;
                step_ch.external_drive <= pending_steps[0].drive;
                step_ch.slow_current   <= pending_steps[0].slow;
                step_ch.time_slot      <= pending_steps[0].slot;
                step_ch.new_step       <= pending_steps[0].new_step;
                send_gap <= pick_gap();
            end else begin
                step_ch.valid <= 1'b0;
            end
        end
    end

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 50) return 0;
        if (k < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // ------------------------------------------------------------------
    // monitor: random back-pressure and field-by-field comparison
    // ------------------------------------------------------------------
    int hold_left = 0;
    bit calm = 0;
    always @(posedge i_clk) begin
        t_result want;
        if (res_ch.valid && res_ch.ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result word id %0d", $time, res_ch.neuron_id);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (res_ch.neuron_id !== want.neuron_id || res_ch.fired !== want.fired ||
                    res_ch.table_slot !== want.slot ||
                    res_ch.table_position !== want.position ||
                    res_ch.table_full !== want.full ||
                    res_ch.membrane !== want.membrane ||
                    res_ch.spike_count !== want.count) begin
                    $display("%0t: mismatch expected id %0d f %0b s %0d p %0d full %0b m %0d c %0d",
                             $time, want.neuron_id, want.fired, want.slot, want.position,
                             want.full, want.membrane, want.count);
                    $display("%0t:          actual id %0d f %0b s %0d p %0d full %0b m %0d c %0d",
                             $time, res_ch.neuron_id, res_ch.fired, res_ch.table_slot,
                             res_ch.table_position, res_ch.table_full, res_ch.membrane,
                             res_ch.spike_count);
                    errors++;
                end
            end
        end
        if (calm || hold_left == 0) begin
            res_ch.ready <= 1'b1;
            hold_left <= calm ? 0 : (($urandom_range(0, 3) == 0) ? pick_gap() : 0);
        end else begin
            res_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        // watchdog on idle cycles
        if ((step_ch.valid && step_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (pending_steps.size() == 0 && expected_results.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        step_ch.valid = 1'b0;
        step_ch.neuron = '0;
        step_ch.excite_in = '0;
        step_ch.inhibit_in = '0;
        step_ch.external_drive = '0;
        step_ch.slow_current = '0;
        step_ch.time_slot = '0;
        step_ch.new_step = 1'b0;
        res_ch.ready = 1'b0;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic wait_drained();
        while (pending_steps.size() != 0 || expected_results.size() != 0 || step_ch.valid)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_REST:      cfg.rest = value;
            REG_MEM_DECAY: cfg.mem_decay = value[16:0];
            REG_EXC_GAIN:  cfg.exc_gain = value;
            REG_INH_GAIN:  cfg.inh_gain = value;
            REG_EXC_DECAY: cfg.exc_decay = value[16:0];
            REG_INH_DECAY: cfg.inh_decay = value[16:0];
            REG_THRESHOLD: cfg.threshold = value;
            REG_RESET_POT: cfg.reset_pot = value;
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rand_word();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return 32'h7FFFFFFF;
        if (k == 1) return 32'h80000000;
        if (k < 5) return $urandom;
        return 32'($signed($urandom_range(0, 2 * 655360)) - 655360);
    endfunction

    // neurons mostly from a small pool so state carries over and refractory hits
    function automatic t_step rand_step(input bit wild);
        t_step s;
        s.neuron     = wild ? 10'($urandom) : 10'($urandom_range(0, 15));
        s.excite_in  = wild ? rand_word() : 32'($urandom_range(0, 400000));
        s.inhibit_in = wild ? rand_word() : 32'($urandom_range(0, 100000));
        s.drive      = wild ? rand_word() : 32'($urandom_range(0, 300000));
        s.slow       = wild ? rand_word() : 32'($urandom_range(0, 200000));
        s.slot       = 4'($urandom);
        s.new_step   = ($urandom_range(0, 19) == 0);
        return s;
    endfunction

    initial begin
        t_step s;
        int phase;
        cfg = '{rest: REST_INIT, mem_decay: 17'd65000, exc_gain: 32'sd65,
                inh_gain: 32'sd65, exc_decay: 17'd64000, inh_decay: 17'd64000,
                threshold: -32'sd3604480, reset_pot: -32'sd4587520};
        for (int i = 0; i < NEURONS; i++) begin
            mem_v[i] = REST_INIT;
            refr_v[i] = '0;
            exc_v[i] = '0;
            inh_v[i] = '0;
            tally_v[i] = '0;
        end
        for (int i = 0; i < SLOTS; i++) fill_v[i] = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, firing, refractory hits
        s = '0;
        s.neuron = 10'd1023; s.excite_in = 32'h7FFFFFFF; s.inhibit_in = 32'h80000000;
        s.drive = 32'h7FFFFFFF; s.slow = 32'h80000000; s.slot = 4'd15; s.new_step = 1;
        pending_steps.push_back(s);
        s.neuron = 10'd0; s.excite_in = 32'h80000000; s.inhibit_in = 32'h7FFFFFFF;
        s.drive = 32'h80000000; s.slow = 32'h7FFFFFFF; s.slot = 4'd0;
        pending_steps.push_back(s);
        for (int i = 0; i < 6; i++) begin
            s = '0;
            s.neuron = 10'd5; s.drive = 32'sd2000000; s.slot = 4'd3;
            pending_steps.push_back(s);
        end
        // sender holds off until everything is back
        wait_drained();

        // slot fill-up: 1030 firings into one slot without clearing
        write_reg(REG_THRESHOLD, 32'h80000000);
        for (int i = 0; i < 1030; i++) begin
            s = '0;
            s.neuron = 10'(i); s.slot = 4'd9; s.new_step = (i == 0);
            s.excite_in = 32'($urandom);
            pending_steps.push_back(s);
        end
        wait_drained();

        // random phases across register settings
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_THRESHOLD, -32'sd3604480);
                    write_reg(REG_EXC_GAIN, 32'sd3000);
                end
                1: begin
                    write_reg(REG_MEM_DECAY, 32'd65536);
                    write_reg(REG_EXC_DECAY, 32'd0);
                    write_reg(REG_INH_DECAY, 32'd65536);
                end
                2: begin
                    write_reg(REG_MEM_DECAY, 32'd131071);
                    write_reg(REG_EXC_DECAY, 32'd131071);
                    write_reg(REG_INH_DECAY, 32'd0);
                end
                3: begin
                    write_reg(REG_REST, 32'h80000000);
                    write_reg(REG_RESET_POT, 32'h7FFFFFFF);
                    write_reg(REG_INH_GAIN, 32'h80000000);
                end
                4: begin
                    write_reg(REG_REST, 32'h7FFFFFFF);
                    write_reg(REG_EXC_GAIN, 32'h7FFFFFFF);
                    write_reg(REG_THRESHOLD, 32'h7FFFFFFF);
                    write_reg(REG_RESET_POT, 32'h80000000);
                end
                5: begin
                    write_reg(REG_EXC_GAIN, 32'h80000000);
                    write_reg(REG_INH_GAIN, 32'h7FFFFFFF);
                    write_reg(REG_MEM_DECAY, 32'd0);
                end
                6: begin
                    write_reg(REG_REST, -32'sd4587520);
                    write_reg(REG_MEM_DECAY, 32'd60000);
                    write_reg(REG_EXC_GAIN, 32'sd20000);
                    write_reg(REG_INH_GAIN, -32'sd20000);
                    write_reg(REG_EXC_DECAY, 32'd50000);
                    write_reg(REG_INH_DECAY, 32'd50000);
                    write_reg(REG_THRESHOLD, -32'sd3604480);
                    write_reg(REG_RESET_POT, -32'sd4587520);
                end
                default: write_reg(REG_THRESHOLD, $urandom);
            endcase
            calm = (phase == 3);
            for (int i = 0; i < 45; i++)
                pending_steps.push_back(rand_step($urandom_range(0, 4) == 0));
            wait_drained();
        end
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
rtl/lifn_pkg.sv
rtl/lifn_in_if.sv
rtl/lifn_out_if.sv
rtl/lifn_ram.sv
rtl/lifn_front.sv
rtl/lifn_back.sv
rtl/lif_neuron_update.sv
dv/lif_neuron_update_test.sv
